// ===== hdl/sqt_pkg.sv =====
// Package for the streaming top-value tracker.
// Holds command codes, value width and the value type; no dependencies.
package sqt_pkg;
  localparam int ValW = 31;
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  typedef logic [ValW-1:0] val_t;
endpackage

// ===== hdl/sqt_if.sv =====
// Valid/ready stream interfaces for the tracker's input and result channels.
// Depends on sqt_pkg for the value type.
interface sqt_in_if;
  import sqt_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  val_t       sample;
  modport source (output valid, cmd, sample, input ready);
  modport sink (input valid, cmd, sample, output ready);
endinterface

interface sqt_out_if;
  import sqt_pkg::*;
  logic valid;
  logic ready;
  val_t top_value;
  logic last;
  logic empty_res;
  modport source (output valid, top_value, last, empty_res, input ready);
  modport sink (input valid, top_value, last, empty_res, output ready);
endinterface

// ===== hdl/stream_top_q_tracker.sv =====
// Streaming top-value tracker. Insert without fill, clear and unused codes finish in the idle state.
// A compaction is a descending insertion sort of the written slots on one comparator and a
// one-write, one-read memory, run when the buffer fills and before a non-empty query's result.
// A query then emits its beats one by one, held while out ready is low; an empty query's beat
// is valid in the cycle after acceptance. Input ready stays low until the item, and its last
// result beat, are done. Synchronous active-low reset empties the buffer and zeroes the threshold.
module stream_top_q_tracker
  import sqt_pkg::*;
#(
  parameter int KEEP_COUNT   = 16,
  parameter int BUFFER_SLOTS = 32
) (
  input logic      clk,
  input logic      rst_n,
  sqt_in_if.sink   in_ch,
  sqt_out_if.source out_ch
);
  localparam int KeepEff = (KEEP_COUNT < BUFFER_SLOTS) ? KEEP_COUNT : BUFFER_SLOTS - 1;
  localparam int AW = $clog2(BUFFER_SLOTS);
  localparam int CW = $clog2(BUFFER_SLOTS + 1);
  localparam logic [CW-1:0] FULL = CW'(BUFFER_SLOTS);
  localparam logic [CW-1:0] KEEP = CW'(KeepEff);

  localparam logic [3:0] S_IDLE = 4'd0, S_SORTI = 4'd1, S_RDV = 4'd2, S_GETV = 4'd3,
                         S_RDJ = 4'd4, S_CMPJ = 4'd5, S_PUT = 4'd6, S_FIN = 4'd7,
                         S_ORD = 4'd8, S_ODATA = 4'd9, S_OWAIT = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt, i_r, i_nxt, j_r, j_nxt;
  val_t          thr_r, thr_nxt, v_r, v_nxt;
  logic          qry_r, qry_nxt;
  val_t          mem [BUFFER_SLOTS];
  val_t          rd_r;
  logic          we;
  logic [AW-1:0] wa, ra;
  val_t          wd;
  val_t          ov_r, ov_nxt;
  logic          ol_r, ol_nxt, oe_r, oe_nxt, ovld_r, ovld_nxt;

  // One-write, one-read slot memory with registered read.
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = ovld_r;
  assign out_ch.top_value = ov_r;
  assign out_ch.last      = ol_r;
  assign out_ch.empty_res = oe_r;

  // Sequencer: command handling, insertion sort driven by one comparator, trim and result output.
  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r; thr_nxt = thr_r; i_nxt = i_r; j_nxt = j_r;
    v_nxt = v_r; qry_nxt = qry_r; ov_nxt = ov_r; ol_nxt = ol_r; oe_nxt = oe_r;
    ovld_nxt = ovld_r && !out_ch.ready;
    we = 1'b0; wa = '0; wd = v_r; ra = '0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          qry_nxt = 1'b0;
          case (in_ch.cmd)
            CMD_INSERT: begin
              if (in_ch.sample >= thr_r) begin
                we = 1'b1; wa = fill_r[AW-1:0]; wd = in_ch.sample;
                fill_nxt = fill_r + 1'b1;
                if (fill_r + 1'b1 == FULL) begin
                  state_nxt = S_SORTI; i_nxt = CW'(1);
                end
              end
            end
            CMD_QUERY: begin
              if (fill_r == '0) begin
                ov_nxt = '0; ol_nxt = 1'b1; oe_nxt = 1'b1; ovld_nxt = 1'b1;
                state_nxt = S_OWAIT;
              end else begin
                qry_nxt = 1'b1; state_nxt = S_SORTI; i_nxt = CW'(1);
              end
            end
            CMD_CLEAR: begin
              fill_nxt = '0; thr_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_SORTI: begin
        if (i_r >= fill_r) state_nxt = S_FIN;
        else state_nxt = S_RDV;
      end
      S_RDV: begin
        ra = i_r[AW-1:0]; state_nxt = S_GETV;
      end
      S_GETV: begin
        v_nxt = rd_r; j_nxt = i_r; state_nxt = S_RDJ;
      end
      S_RDJ: begin
        if (j_r == '0) state_nxt = S_PUT;
        else begin
          ra = AW'(j_r - 1'b1); state_nxt = S_CMPJ;
        end
      end
      S_CMPJ: begin
        if (rd_r < v_r) begin
          we = 1'b1; wa = j_r[AW-1:0]; wd = rd_r;
          j_nxt = j_r - 1'b1; state_nxt = S_RDJ;
        end else state_nxt = S_PUT;
      end
      S_PUT: begin
        we = 1'b1; wa = j_r[AW-1:0]; wd = v_r;
        i_nxt = i_r + 1'b1; state_nxt = S_SORTI;
      end
      S_FIN: begin
        ra = AW'(KEEP - 1'b1);
        if (fill_r >= KEEP) begin
          fill_nxt = KEEP; state_nxt = S_ORD;
        end else if (qry_r) begin
          i_nxt = '0; state_nxt = S_ORD;
        end else state_nxt = S_IDLE;
        i_nxt = '0;
      end
      S_ORD: begin
        // rd_r now holds the smallest kept value when trimmed.
        if (fill_r == KEEP) thr_nxt = rd_r;
        if (qry_r) begin
          ra = i_r[AW-1:0]; state_nxt = S_ODATA;
        end else state_nxt = S_IDLE;
      end
      S_ODATA: begin
        if (!ovld_r || out_ch.ready) begin
          ov_nxt = rd_r; oe_nxt = 1'b0; ol_nxt = (i_r + 1'b1 == fill_r);
          ovld_nxt = 1'b1;
          if (i_r + 1'b1 == fill_r) state_nxt = S_OWAIT;
          else begin
            i_nxt = i_r + 1'b1; ra = AW'(i_r + 1'b1); state_nxt = S_ORD;
          end
        end else ra = i_r[AW-1:0];
      end
      S_OWAIT: begin
        if (!ovld_nxt) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; fill_r <= '0; thr_r <= '0; ovld_r <= 1'b0;
    end else begin
      state_r <= state_nxt; fill_r <= fill_nxt; thr_r <= thr_nxt; ovld_r <= ovld_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; v_r <= v_nxt; qry_r <= qry_nxt;
    ov_r <= ov_nxt; ol_r <= ol_nxt; oe_r <= oe_nxt;
  end
endmodule

// ===== sim/sqt_checker.sv =====
// Checker for the streaming top-value tracker: watches both channels,
// keeps its own copy of the tracker state and compares every result beat.
// Depends on sqt_pkg and the channel interfaces in sqt_if.
module sqt_checker
  import sqt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  sqt_in_if    in_ch,
  sqt_out_if   out_ch,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Keep  = 16;
  localparam int Slots = 32;

  typedef struct packed {
    val_t top_value;
    logic last;
    logic empty_res;
  } top_beat_t;

  logic [31:0] slot_copy [Slots];
  int          fill_copy;
  logic [31:0] thresh_copy;
  top_beat_t   top_queue [$];

  // Prints one line for a mismatch and counts it.
  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Sorts the written slots downwards and trims to the kept count.
  task automatic compact_slots();
    logic [31:0] v;
    int j;
    for (int i = 1; i < fill_copy; i++) begin
      v = slot_copy[i];
      j = i;
      while (j > 0 && slot_copy[j-1] < v) begin
        slot_copy[j] = slot_copy[j-1];
        j--;
      end
      slot_copy[j] = v;
    end
    if (fill_copy >= Keep) begin
      fill_copy   = Keep;
      thresh_copy = slot_copy[Keep-1];
    end
  endtask

  // Applies one accepted command and queues the beats it should produce.
  task automatic apply_command(input logic [1:0] cmd, input val_t sample);
    top_beat_t b;
    case (cmd)
      CMD_INSERT: begin
        if ({1'b0, sample} >= thresh_copy) begin
          if (fill_copy < Slots) begin
            slot_copy[fill_copy] = {1'b0, sample};
            fill_copy++;
          end
          if (fill_copy >= Slots) compact_slots();
        end
      end
      CMD_QUERY: begin
        if (fill_copy == 0) begin
          b = '{top_value: '0, last: 1'b1, empty_res: 1'b1};
          top_queue.push_back(b);
        end else begin
          compact_slots();
          for (int i = 0; i < fill_copy; i++) begin
            b = '{top_value: slot_copy[i][ValW-1:0], last: (i == fill_copy - 1),
                  empty_res: 1'b0};
            top_queue.push_back(b);
          end
        end
      end
      CMD_CLEAR: begin
        fill_copy   = 0;
        thresh_copy = '0;
      end
      default: ;
    endcase
  endtask

  initial begin
    errors      = 0;
    pending     = 0;
    fill_copy   = 0;
    thresh_copy = '0;
  end

  // Result beats are compared first, then the accepted command is applied.
  always @(posedge clk) begin
    top_beat_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (top_queue.size() == 0) begin
          report($sformatf("unexpected result beat value %0d", out_ch.top_value));
        end else begin
          want = top_queue.pop_front();
          if (out_ch.top_value !== want.top_value)
            report($sformatf("top_value %0d, wanted %0d", out_ch.top_value,
                             want.top_value));
          if (out_ch.last !== want.last)
            report($sformatf("last %b, wanted %b", out_ch.last, want.last));
          if (out_ch.empty_res !== want.empty_res)
            report($sformatf("empty_res %b, wanted %b", out_ch.empty_res,
                             want.empty_res));
        end
      end
      if (in_ch.valid && in_ch.ready) apply_command(in_ch.cmd, in_ch.sample);
      pending = top_queue.size();
    end
  end
endmodule

// ===== sim/stream_top_q_tracker_test.sv =====
// Top of the tracker testbench: clock, reset, command stimulus and verdict.
// Depends on sqt_pkg, sqt_if, the tracker RTL and sqt_checker.
module stream_top_q_tracker_test;
  import sqt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic calm = 1'b0;
  int   errors;
  int   pending;

  sqt_in_if  in_if ();
  sqt_out_if out_if ();

  stream_top_q_tracker u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  sqt_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .errors  (errors),
    .pending (pending)
  );

  always #6 clk = ~clk;

  // Result side drops ready at random, about nine times in a hundred, outside calm stretches.
  initial out_if.ready = 1'b0;
  always @(negedge clk) begin
    out_if.ready <= calm || ($urandom_range(99) >= 9);
  end

  // Offers one command beat and holds it until the tracker takes it.
  // Valid is left high on return; the next beat or the caller replaces it.
  task automatic send(input logic [1:0] cmd, input val_t sample);
    while (!calm && $urandom_range(99) < 9) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.cmd    <= cmd;
    in_if.sample <= sample;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // Random sample: often small so duplicates and threshold hits occur.
  function automatic val_t pick_sample();
    case ($urandom_range(3))
      0:       pick_sample = val_t'($urandom_range(20));
      1:       pick_sample = val_t'($urandom_range(1000));
      default: pick_sample = val_t'($urandom());
    endcase
  endfunction

  // Generous backstop for a hung run.
  initial begin
    #30ms;
    $display("stream_top_q_tracker_test failed");
    $finish;
  end

  initial begin
    int roll;
    in_if.valid  = 1'b0;
    in_if.cmd    = CMD_INSERT;
    in_if.sample = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty query, extreme samples, duplicates, unused code, clear.
    send(CMD_QUERY, '0);
    send(CMD_INSERT, '1);
    send(CMD_INSERT, '0);
    send(CMD_INSERT, val_t'(5));
    send(CMD_INSERT, val_t'(5));
    send(CMD_UNUSED, val_t'(77));
    send(CMD_QUERY, '1);
    send(CMD_CLEAR, '1);
    send(CMD_QUERY, '0);
    send(CMD_INSERT, val_t'(31'h2AAAAAAA));
    send(CMD_INSERT, val_t'(31'h55555555));
    send(CMD_QUERY, '0);
    send(CMD_CLEAR, '0);

    // Random: mostly inserts so the buffer fills and compacts repeatedly.
    for (int n = 0; n < 160; n++) begin
      calm = (n >= 60 && n < 100);
      if (n == 120) begin
        // Hold off until every pending result beat has drained.
        in_if.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      roll = $urandom_range(99);
      if (roll < 80)      send(CMD_INSERT, pick_sample());
      else if (roll < 92) send(CMD_QUERY, val_t'($urandom()));
      else if (roll < 97) send(CMD_CLEAR, val_t'($urandom()));
      else                send(CMD_UNUSED, val_t'($urandom()));
    end
    send(CMD_QUERY, '0);
    in_if.valid <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (3000) @(posedge clk);
    if (errors == 0) begin
      $display("stream_top_q_tracker_test passed");
    end else begin
      $display("stream_top_q_tracker_test failed");
    end
    $finish;
  end
endmodule
